// ===== hdl/ttlex_pkg.sv =====
package ttlex_pkg;

  localparam int FRAC_DIGITS_MAX = 8;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_STRING,
    MODE_NUMBER,
    MODE_COMMENT
  } mode_t;

  typedef enum logic [3:0] {
    K_ID_CHAR,
    K_ID_END,
    K_STR_CHAR,
    K_STR_END,
    K_INT,
    K_DEC,
    K_COLON,
    K_LPAREN,
    K_RPAREN,
    K_LBRACE,
    K_RBRACE,
    K_INVALID,
    K_EOF
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         text_char;
    logic signed [31:0] int_value;
    logic               negative;
    logic [26:0]        frac_value;
    logic [3:0]         frac_digits;
    logic [31:0]        line_number;
    logic               last;
  } res_t;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

endpackage

// ===== hdl/ttlex_core.sv =====
module ttlex_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            go,
  input  logic [7:0]      data_byte,
  input  logic            end_of_file,
  output ttlex_pkg::res_t res0,
  output ttlex_pkg::res_t res1,
  output logic [1:0]      res_count
);
  import ttlex_pkg::*;

  mode_t       mode, mode_next;
  logic [31:0] int_accum, int_accum_next;
  logic [26:0] frac_accum, frac_accum_next;
  logic [3:0]  frac_count, frac_count_next;
  logic        in_fraction, in_fraction_next;
  logic        minus_seen, minus_seen_next;
  logic [31:0] line_count, line_count_next;
  logic [31:0] token_line, token_line_next;

  logic        is_letter, is_digit, is_space, ident_cont;
  logic [3:0]  digit;
  logic        pre_valid, idle_valid, do_idle;
  res_t        pre_res, idle_res, close_res;

  always_comb begin
    is_letter  = (data_byte >= CH_LA && data_byte <= CH_LZ) ||
                 (data_byte >= CH_UA && data_byte <= CH_UZ);
    is_digit   = data_byte >= CH_0 && data_byte <= CH_9;
    is_space   = data_byte == CH_SPACE || data_byte == CH_TAB ||
                 data_byte == CH_LF || data_byte == CH_CR;
    ident_cont = is_letter || is_digit || data_byte == CH_UNDER;
    digit      = data_byte[3:0];
  end

  // result for the running number as it stands
  always_comb begin
    close_res             = '0;
    close_res.line_number = token_line;
    if (in_fraction) begin
      close_res.kind        = K_DEC;
      close_res.int_value   = int_accum;
      close_res.negative    = minus_seen;
      close_res.frac_value  = frac_accum;
      close_res.frac_digits = frac_count;
    end else begin
      close_res.kind      = K_INT;
      close_res.int_value = minus_seen ? 32'(-int_accum) : int_accum;
    end
  end

  always_comb begin
    mode_next        = mode;
    int_accum_next   = int_accum;
    frac_accum_next  = frac_accum;
    frac_count_next  = frac_count;
    in_fraction_next = in_fraction;
    minus_seen_next  = minus_seen;
    line_count_next  = line_count;
    token_line_next  = token_line;
    pre_valid        = 1'b0;
    pre_res          = '0;
    idle_valid       = 1'b0;
    idle_res         = '0;
    do_idle          = 1'b0;
    res0             = '0;
    res1             = '0;
    res_count        = 2'd0;

    if (end_of_file) begin
      pre_res.line_number = token_line;
      case (mode)
        MODE_IDENT: begin
          pre_valid    = 1'b1;
          pre_res.kind = K_ID_END;
        end
        MODE_STRING: begin
          pre_valid    = 1'b1;
          pre_res.kind = K_STR_END;
        end
        MODE_NUMBER: begin
          pre_valid = 1'b1;
          pre_res   = close_res;
        end
        default: ;
      endcase
      mode_next            = MODE_IDLE;
      idle_valid           = 1'b1;
      idle_res.kind        = K_EOF;
      idle_res.line_number = line_count;
    end else begin
      case (mode)
        MODE_IDENT: begin
          pre_valid           = 1'b1;
          pre_res.line_number = token_line;
          if (ident_cont) begin
            pre_res.kind      = K_ID_CHAR;
            pre_res.text_char = data_byte;
          end else begin
            pre_res.kind = K_ID_END;
            do_idle      = 1'b1;
          end
        end
        MODE_STRING: begin
          pre_valid           = 1'b1;
          pre_res.line_number = token_line;
          if (data_byte == CH_QUOTE) begin
            pre_res.kind = K_STR_END;
            mode_next    = MODE_IDLE;
          end else begin
            pre_res.kind      = K_STR_CHAR;
            pre_res.text_char = data_byte;
          end
        end
        MODE_NUMBER: begin
          if (data_byte == CH_DOT && !in_fraction) begin
            in_fraction_next = 1'b1;
          end else if (is_digit) begin
            if (!in_fraction) begin
              int_accum_next = (int_accum << 3) + (int_accum << 1) + 32'(digit);
            end else if (frac_count < 4'(FRAC_DIGITS_MAX)) begin
              frac_accum_next = (frac_accum << 3) + (frac_accum << 1) + 27'(digit);
              frac_count_next = frac_count + 4'd1;
            end
          end else begin
            pre_valid = 1'b1;
            pre_res   = close_res;
            do_idle   = 1'b1;
          end
        end
        MODE_COMMENT: begin
          do_idle = data_byte == CH_LF || data_byte == CH_CR;
        end
        default: do_idle = 1'b1;
      endcase

      if (do_idle) begin
        mode_next            = MODE_IDLE;
        idle_res.line_number = line_count;
        if (is_letter || data_byte == CH_UNDER) begin
          token_line_next    = line_count;
          mode_next          = MODE_IDENT;
          idle_valid         = 1'b1;
          idle_res.kind      = K_ID_CHAR;
          idle_res.text_char = data_byte;
        end else if (is_digit || data_byte == CH_MINUS) begin
          token_line_next  = line_count;
          mode_next        = MODE_NUMBER;
          minus_seen_next  = data_byte == CH_MINUS;
          int_accum_next   = is_digit ? 32'(digit) : 32'd0;
          frac_accum_next  = '0;
          frac_count_next  = '0;
          in_fraction_next = 1'b0;
        end else if (data_byte == CH_QUOTE) begin
          token_line_next = line_count;
          mode_next       = MODE_STRING;
        end else if (data_byte == CH_HASH) begin
          mode_next = MODE_COMMENT;
        end else if (is_space) begin
          if (data_byte == CH_LF) line_count_next = line_count + 32'd1;
        end else begin
          idle_valid = 1'b1;
          case (data_byte)
            CH_COLON:  idle_res.kind = K_COLON;
            CH_LPAREN: idle_res.kind = K_LPAREN;
            CH_RPAREN: idle_res.kind = K_RPAREN;
            CH_LBRACE: idle_res.kind = K_LBRACE;
            CH_RBRACE: idle_res.kind = K_RBRACE;
            default: begin
              idle_res.kind      = K_INVALID;
              idle_res.text_char = data_byte;
            end
          endcase
        end
      end
    end

    // pack into slots; closing result goes first
    if (pre_valid && idle_valid) begin
      res0          = pre_res;
      res1          = idle_res;
      res1.last     = 1'b1;
      res_count     = 2'd2;
    end else if (pre_valid) begin
      res0          = pre_res;
      res0.last     = 1'b1;
      res_count     = 2'd1;
    end else if (idle_valid) begin
      res0          = idle_res;
      res0.last     = 1'b1;
      res_count     = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      int_accum   <= '0;
      frac_accum  <= '0;
      frac_count  <= '0;
      in_fraction <= 1'b0;
      minus_seen  <= 1'b0;
      line_count  <= 32'd1;
      token_line  <= 32'd1;
    end else if (go) begin
      mode        <= mode_next;
      int_accum   <= int_accum_next;
      frac_accum  <= frac_accum_next;
      frac_count  <= frac_count_next;
      in_fraction <= in_fraction_next;
      minus_seen  <= minus_seen_next;
      line_count  <= line_count_next;
      token_line  <= token_line_next;
    end
  end

endmodule

// ===== hdl/ttlex_queue.sv =====
module ttlex_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic [1:0]      push_count,
  input  ttlex_pkg::res_t push0,
  input  ttlex_pkg::res_t push1,
  input  logic            pop_ready,
  output logic            room,
  output logic            head_valid,
  output ttlex_pkg::res_t head
);
  import ttlex_pkg::*;

  res_t       slots [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;
  logic       pop;

  assign head_valid = count != 3'd0;
  assign head       = slots[rd_ptr];
  assign pop        = head_valid && pop_ready;
  // two free slots after this cycle's pop
  assign room       = (count <= 3'd2) || (count == 3'd3 && pop);

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) slots[wr_ptr] <= push0;
    if (push_count == 2'd2) slots[wr_ptr + 2'd1] <= push1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_count;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count + {1'b0, push_count} - {2'b00, pop};
    end
  end

endmodule

// ===== hdl/text_token_lexer_top.sv =====
// channel | signals                                   | direction
// in      | in_valid, in_ready, data_byte, end_of_file | into block
// out     | out_valid, out_ready, token_kind .. last_of_step | out of block
//
// One byte is taken per cycle while the queue has room; its results pass the input
// register and then the queue.  Results leave at one per cycle while out_ready is
// high, through a four-entry queue, so a byte with two results needs two pops.
// Synchronous reset puts the lexer idle with line count one and empties the queue.
// A stalled output fills the queue, then holds the input register, then in_ready.
module text_token_lexer_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               end_of_file,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         token_kind,
  output logic [7:0]         text_char,
  output logic signed [31:0] int_value,
  output logic               negative,
  output logic [26:0]        frac_value,
  output logic [3:0]         frac_digits,
  output logic [31:0]        line_number,
  output logic               last_of_step
);
  import ttlex_pkg::*;

  logic       ir_valid;
  logic [7:0] ir_byte;
  logic       ir_eof;
  logic       room, go;
  logic [1:0] res_count;
  res_t       res0, res1, head;

  assign go       = ir_valid && room;
  assign in_ready = !ir_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (in_ready) begin
      ir_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ir_byte <= data_byte;
      ir_eof  <= end_of_file;
    end
  end

  ttlex_core u_core (
    .clk         (clk),
    .rst         (rst),
    .go          (go),
    .data_byte   (ir_byte),
    .end_of_file (ir_eof),
    .res0        (res0),
    .res1        (res1),
    .res_count   (res_count)
  );

  ttlex_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_count (go ? res_count : 2'd0),
    .push0      (res0),
    .push1      (res1),
    .pop_ready  (out_ready),
    .room       (room),
    .head_valid (out_valid),
    .head       (head)
  );

  assign token_kind   = head.kind;
  assign text_char    = head.text_char;
  assign int_value    = head.int_value;
  assign negative     = head.negative;
  assign frac_value   = head.frac_value;
  assign frac_digits  = head.frac_digits;
  assign line_number  = head.line_number;
  assign last_of_step = head.last;

endmodule

// ===== verif/tb_text_token_lexer_top.sv =====
module tb_text_token_lexer_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ttlex_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       eof;
  } text_beat_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         data_byte = 8'h00;
  logic               end_of_file = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [3:0]         token_kind;
  logic [7:0]         text_char;
  logic signed [31:0] int_value;
  logic               negative;
  logic [26:0]        frac_value;
  logic [3:0]         frac_digits;
  logic [31:0]        line_number;
  logic               last_of_step;

  text_token_lexer_top dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // lexer state as predicted
  mode_t       lx_mode = MODE_IDLE;
  logic [31:0] num_int = '0;
  logic [26:0] num_frac = '0;
  logic [3:0]  frac_kept = '0;
  logic        in_frac = 1'b0;
  logic        minus = 1'b0;
  logic [31:0] cur_line = 32'd1;
  logic [31:0] tok_line = 32'd1;

  res_t       step_buf [2];
  int         step_n;
  res_t       tokens_due [$];
  text_beat_t pending_text [$];

  int items_queued = 0;
  int bytes_taken = 0;
  int tokens_seen = 0;
  int mismatches = 0;
  int send_idle_pct = 13;
  int recv_idle_pct = 51;
  int stall_left = 0;
  bit long_stall_done = 1'b0;
  bit in_took = 1'b0;

  function automatic bit is_letter(input logic [7:0] b);
    return (b >= CH_LA && b <= CH_LZ) || (b >= CH_UA && b <= CH_UZ);
  endfunction

  function automatic bit is_digit(input logic [7:0] b);
    return b >= CH_0 && b <= CH_9;
  endfunction

  task automatic note_token(input kind_t k, input logic [31:0] ln,
                            input logic [7:0] ch = 8'h00, input logic [31:0] iv = '0,
                            input logic neg = 1'b0, input logic [26:0] fv = '0,
                            input logic [3:0] fd = '0);
    res_t r;
    r.kind        = k;
    r.text_char   = ch;
    r.int_value   = iv;
    r.negative    = neg;
    r.frac_value  = fv;
    r.frac_digits = fd;
    r.line_number = ln;
    r.last        = 1'b0;
    if (step_n < 2) begin
      step_buf[step_n] = r;
      step_n++;
    end
  endtask

  task automatic close_number();
    if (!in_frac) begin
      note_token(K_INT, tok_line, 8'h00, minus ? 32'd0 - num_int : num_int);
    end else begin
      note_token(K_DEC, tok_line, 8'h00, num_int, minus, num_frac, frac_kept);
    end
    lx_mode = MODE_IDLE;
  endtask

  // byte met with no token running
  task automatic start_token(input logic [7:0] b);
    lx_mode = MODE_IDLE;
    if (is_letter(b) || b == CH_UNDER) begin
      tok_line = cur_line;
      lx_mode = MODE_IDENT;
      note_token(K_ID_CHAR, tok_line, b);
    end else if (is_digit(b) || b == CH_MINUS) begin
      tok_line = cur_line;
      lx_mode = MODE_NUMBER;
      minus = (b == CH_MINUS);
      num_int = minus ? 32'd0 : 32'(b - CH_0);
      num_frac = '0;
      frac_kept = '0;
      in_frac = 1'b0;
    end else begin
      case (b)
        CH_QUOTE: begin
          tok_line = cur_line;
          lx_mode = MODE_STRING;
        end
        CH_HASH: lx_mode = MODE_COMMENT;
        CH_SPACE, CH_TAB, CH_CR: ;
        CH_LF: cur_line++;
        CH_COLON: note_token(K_COLON, cur_line);
        CH_LPAREN: note_token(K_LPAREN, cur_line);
        CH_RPAREN: note_token(K_RPAREN, cur_line);
        CH_LBRACE: note_token(K_LBRACE, cur_line);
        CH_RBRACE: note_token(K_RBRACE, cur_line);
        default: note_token(K_INVALID, cur_line, b);
      endcase
    end
  endtask

  task automatic lex_byte(input logic [7:0] b, input logic eof);
    step_n = 0;
    if (eof) begin
      case (lx_mode)
        MODE_IDENT: note_token(K_ID_END, tok_line);
        MODE_STRING: note_token(K_STR_END, tok_line);
        MODE_NUMBER: close_number();
        default: ;
      endcase
      lx_mode = MODE_IDLE;
      note_token(K_EOF, cur_line);
    end else begin
      case (lx_mode)
        MODE_IDENT: begin
          if (is_letter(b) || is_digit(b) || b == CH_UNDER) begin
            note_token(K_ID_CHAR, tok_line, b);
          end else begin
            note_token(K_ID_END, tok_line);
            start_token(b);
          end
        end
        MODE_STRING: begin
          if (b == CH_QUOTE) begin
            note_token(K_STR_END, tok_line);
            lx_mode = MODE_IDLE;
          end else begin
            note_token(K_STR_CHAR, tok_line, b);
          end
        end
        MODE_NUMBER: begin
          if (b == CH_DOT && !in_frac) begin
            in_frac = 1'b1;
          end else if (is_digit(b)) begin
            if (!in_frac) begin
              num_int = num_int * 32'd10 + 32'(b - CH_0);
            end else if (frac_kept < FRAC_DIGITS_MAX) begin
              num_frac = num_frac * 27'd10 + 27'(b - CH_0);
              frac_kept++;
            end
          end else begin
            close_number();
            start_token(b);
          end
        end
        MODE_COMMENT: begin
          if (b == CH_LF || b == CH_CR) start_token(b);
        end
        default: start_token(b);
      endcase
    end
    if (step_n > 0) step_buf[step_n - 1].last = 1'b1;
    for (int i = 0; i < step_n; i++) tokens_due.push_back(step_buf[i]);
  endtask

  function automatic string show(input res_t r);
    return $sformatf("kind %0d char %02h int %0d neg %0b frac %0d/%0d line %0d last %0b",
                     r.kind, r.text_char, r.int_value, r.negative, r.frac_value,
                     r.frac_digits, r.line_number, r.last);
  endfunction

  // sample both channels at the rising edge
  always @(posedge clk) begin
    res_t got, want;
    in_took = !rst && in_valid && in_ready;
    if (in_took) begin
      lex_byte(data_byte, end_of_file);
      bytes_taken++;
    end
    if (!rst && out_valid && out_ready) begin
      got.kind        = kind_t'(token_kind);
      got.text_char   = text_char;
      got.int_value   = int_value;
      got.negative    = negative;
      got.frac_value  = frac_value;
      got.frac_digits = frac_digits;
      got.line_number = line_number;
      got.last        = last_of_step;
      if (tokens_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("token %0d not expected: %s", tokens_seen, show(got));
      end else begin
        want = tokens_due.pop_front();
        if (got.kind !== want.kind || got.text_char !== want.text_char ||
            got.int_value !== want.int_value || got.negative !== want.negative ||
            got.frac_value !== want.frac_value || got.frac_digits !== want.frac_digits ||
            got.line_number !== want.line_number || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("token %0d expected %s", tokens_seen, show(want));
            $display("token %0d actual   %s", tokens_seen, show(got));
          end
        end
      end
      tokens_seen++;
    end
  end

  // text byte driver
  always @(negedge clk) begin
    text_beat_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (pending_text.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_text.pop_front();
        data_byte <= nxt.ch;
        end_of_file <= nxt.eof;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // token receiver; one long hold-off early on so the output queue backs up
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (!long_stall_done && bytes_taken >= 150) begin
        stall_left = 200;
        long_stall_done = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic queue_beat(input logic [7:0] b, input logic eof = 1'b0);
    text_beat_t t;
    t.ch = b;
    t.eof = eof;
    pending_text.push_back(t);
    items_queued++;
  endtask

  task automatic queue_str(input string s);
    for (int i = 0; i < s.len(); i++) queue_beat(s[i]);
  endtask

  function automatic logic [7:0] rand_digit();
    return CH_0 + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_word_char(input bit first);
    int pick;
    pick = $urandom_range(first ? 52 : 62);
    if (pick < 26) return CH_LA + 8'(pick);
    if (pick < 52) return CH_UA + 8'(pick - 26);
    if (pick == 52) return CH_UNDER;
    return rand_digit();
  endfunction

  // mostly well-formed tokens with random content, some noise and cut-off tokens
  task automatic queue_text(input int n_items);
    int goal, len, pick;
    bit neg;
    logic [7:0] b;
    goal = items_queued + n_items;
    while (items_queued < goal) begin
      pick = $urandom_range(99);
      if (pick < 22) begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) queue_beat(rand_word_char(i == 0));
      end else if (pick < 36) begin
        queue_beat(CH_QUOTE);
        len = $urandom_range(0, 6);
        for (int i = 0; i < len; i++) begin
          do b = 8'($urandom_range(255)); while (b == CH_QUOTE);
          queue_beat(b);
        end
        if ($urandom_range(9) != 0) queue_beat(CH_QUOTE);
      end else if (pick < 60) begin
        neg = ($urandom_range(2) == 0);
        if (neg) queue_beat(CH_MINUS);
        // long digit runs wrap the integer part
        len = ($urandom_range(7) == 0) ? $urandom_range(10, 13) : $urandom_range(0, 4);
        if (!neg && len == 0) len = 1;
        for (int i = 0; i < len; i++) queue_beat(rand_digit());
        if ($urandom_range(1) == 0) begin
          queue_beat(CH_DOT);
          len = ($urandom_range(3) == 0) ? $urandom_range(8, 11) : $urandom_range(0, 7);
          for (int i = 0; i < len; i++) queue_beat(rand_digit());
          if ($urandom_range(9) == 0) queue_beat(CH_DOT);
        end
      end else if (pick < 66) begin
        queue_beat(CH_HASH);
        len = $urandom_range(0, 5);
        for (int i = 0; i < len; i++) begin
          do b = 8'($urandom_range(255)); while (b == CH_LF || b == CH_CR);
          queue_beat(b);
        end
        if ($urandom_range(5) != 0) queue_beat($urandom_range(1) ? CH_LF : CH_CR);
      end else if (pick < 80) begin
        case ($urandom_range(3))
          0: queue_beat(CH_SPACE);
          1: queue_beat(CH_TAB);
          2: queue_beat(CH_CR);
          default: queue_beat(CH_LF);
        endcase
      end else if (pick < 90) begin
        case ($urandom_range(4))
          0: queue_beat(CH_COLON);
          1: queue_beat(CH_LPAREN);
          2: queue_beat(CH_RPAREN);
          3: queue_beat(CH_LBRACE);
          default: queue_beat(CH_RBRACE);
        endcase
      end else if (pick < 97) begin
        queue_beat(8'($urandom_range(255)));
      end else begin
        queue_beat(8'($urandom_range(255)), 1'b1);
      end
      // no separator half the time, so one byte closes a token and opens the next
      if ($urandom_range(1) == 0) queue_beat($urandom_range(3) == 0 ? CH_LF : CH_SPACE);
    end
  endtask

  task automatic wait_text_drained();
    while (bytes_taken != items_queued || tokens_due.size() != 0) @(negedge clk);
  endtask

  initial begin
    // directed opening: ident closed by a bracket, string with newline, lone minus,
    // second dot closing a decimal, comment to end of line, byte extremes, eof cases
    queue_str("a_Z9(");
    queue_str("\"x\n\"");
    queue_str("-)");
    queue_str("1.2.");
    queue_str("#x\n");
    queue_str(":{");
    queue_beat(8'h00);
    queue_beat(8'hFF);
    queue_beat(8'h00, 1'b1);
    queue_str("ab");
    queue_beat(8'hFF, 1'b1);
    queue_text(360);
    repeat (10) @(negedge clk);
    rst = 1'b0;
    wait_text_drained();
    send_idle_pct = 51;
    recv_idle_pct = 13;
    queue_text(360);
    wait_text_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_text(360);
    wait_text_drained();
    repeat (20) @(negedge clk);
    if (mismatches == 0 && tokens_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== text_token_lexer_top.f =====
hdl/ttlex_pkg.sv
hdl/ttlex_core.sv
hdl/ttlex_queue.sv
hdl/text_token_lexer_top.sv
verif/tb_text_token_lexer_top.sv
